### rtl/core/pink_noise_filter_refined_top_defines.svh
// ----------------------------------------------------------------------------
// Pink noise filter assertion macros
// Shared assertion wrappers for the pink noise filter design.
// ----------------------------------------------------------------------------
`ifndef PINK_NOISE_FILTER_REFINED_TOP_DEFINES_SVH
`define PINK_NOISE_FILTER_REFINED_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PNF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PNF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PNF_ASSERT(label, prop, msg)
`define PNF_ASSERT_RST(label, prop, msg)
`endif

`endif

### rtl/core/pnf_pkg.sv
// ----------------------------------------------------------------------------
// Pink noise filter package
// Formats and fixed coefficients shared by the pink noise filter modules.
// ----------------------------------------------------------------------------
package pnf_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ACC_WIDTH    = 24;
    localparam int COEF_WIDTH   = 19;
    localparam int COEF_FRAC    = 18;
    localparam int NUM_POLES    = 6;

    typedef logic signed [COEF_WIDTH-1:0] coef_t;

    localparam coef_t POLE_GAIN [NUM_POLES] = '{
        19'sd261845, 19'sd260393, 19'sd254018, 19'sd227148, 19'sd144179, -19'sd199649
    };

    localparam coef_t POLE_FEED [NUM_POLES] = '{
        19'sd14554, 19'sd19681, 19'sd40331, 19'sd81392, 19'sd139710, -19'sd4430
    };

    localparam coef_t DIRECT_GAIN = 19'sd140562;
    localparam coef_t DELAY_GAIN  = 19'sd30389;

endpackage

### rtl/core/pink_noise_filter_refined_top.sv
// ----------------------------------------------------------------------------
// Pink noise filter, refined pole set
// Stages: input register, stage two poles and terms, output sum register.
// Throughput: one item per cycle when not stalled; one multiply-add pole loop.
// Reset: poles, delayed term and all valid flags clear asynchronously to zero.
// ----------------------------------------------------------------------------
`include "pink_noise_filter_refined_top_defines.svh"

module pink_noise_filter_refined_top #(
    parameter int SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH,
    parameter int ACC_WIDTH    = pnf_pkg::ACC_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] white_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [ACC_WIDTH-1:0]    pink_sample
);

    logic                           in_valid_reg;
    logic                           in_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] white_reg;
    logic                           s2_valid_reg;
    logic                           s2_valid_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic signed [ACC_WIDTH-1:0]    delay_reg;
    logic signed [ACC_WIDTH-1:0]    delay_used_reg;
    logic signed [ACC_WIDTH-1:0]    direct_reg;
    logic signed [ACC_WIDTH-1:0]    direct_term;
    logic signed [ACC_WIDTH-1:0]    delay_term;
    logic signed [ACC_WIDTH-1:0]    poles [pnf_pkg::NUM_POLES];
    logic                           out_ready;
    logic                           s2_ready;
    logic                           s1_ready;
    logic                           in_load;
    logic                           s2_load;
    logic                           out_load;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !in_valid_reg || s2_ready;
    assign in_load   = in_valid && s1_ready;
    assign s2_load   = in_valid_reg && s2_ready;
    assign out_load  = s2_valid_reg && out_ready;

    assign in_stall  = !s1_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_load)
        begin
            in_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            in_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            delay_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s2_load)
            begin
                delay_reg <= delay_term;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            white_reg <= white_sample;
        end
        if (s2_load)
        begin
            delay_used_reg <= delay_reg;
            direct_reg     <= direct_term;
        end
    end

    for (genvar i = 0; i < pnf_pkg::NUM_POLES; i++)
    begin : g_pole
        pnf_pole #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .ACC_WIDTH    (ACC_WIDTH),
            .GAIN         (pnf_pkg::POLE_GAIN[i]),
            .FEED         (pnf_pkg::POLE_FEED[i])
        ) u_pole (
            .clk   (clk),
            .rst_n (rst_n),
            .load  (s2_load),
            .white (white_reg),
            .pole  (poles[i])
        );
    end

    pnf_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH),
        .COEF         (pnf_pkg::DIRECT_GAIN)
    ) u_direct (
        .white (white_reg),
        .term  (direct_term)
    );

    pnf_scale #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ACC_WIDTH    (ACC_WIDTH),
        .COEF         (pnf_pkg::DELAY_GAIN)
    ) u_delay (
        .white (white_reg),
        .term  (delay_term)
    );

    pnf_sum #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_sum (
        .clk     (clk),
        .load    (out_load),
        .poles   (poles),
        .delayed (delay_used_reg),
        .direct  (direct_reg),
        .result  (pink_sample)
    );

    `PNF_ASSERT(a_empty_no_stall, !in_valid_reg |-> !in_stall, "input stalled while empty")
    `PNF_ASSERT(a_out_from_s2, $rose(out_valid_reg) |-> $past(s2_valid_reg), "output without stage two item")
    `PNF_ASSERT(a_delay_hold, !s2_load |=> $stable(delay_reg), "delayed term changed without an item")
    `PNF_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid && !in_valid_reg, "pipeline valid in reset")

endmodule

### rtl/core/pnf_pole.sv
// ----------------------------------------------------------------------------
// Pink noise filter pole
// One-pole lowpass accumulator with rounding and saturation.
// ----------------------------------------------------------------------------
module pnf_pole #(
    parameter int             SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH,
    parameter int             ACC_WIDTH    = pnf_pkg::ACC_WIDTH,
    parameter pnf_pkg::coef_t GAIN         = '0,
    parameter pnf_pkg::coef_t FEED         = '0
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  logic signed [SAMPLE_WIDTH-1:0] white,
    output logic signed [ACC_WIDTH-1:0]    pole
);

    localparam int WIDE = (ACC_WIDTH > SAMPLE_WIDTH) ? ACC_WIDTH : SAMPLE_WIDTH;
    localparam int PW   = WIDE + pnf_pkg::COEF_WIDTH + 1;

    localparam logic signed [PW-1:0] HALF =
        {{(PW-pnf_pkg::COEF_FRAC){1'b0}}, 1'b1, {(pnf_pkg::COEF_FRAC-1){1'b0}}};
    localparam logic signed [PW-1:0] ACC_MAX =
        {{(PW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [PW-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [ACC_WIDTH-1:0]                      pole_reg;
    logic signed [ACC_WIDTH-1:0]                      pole_next;
    logic signed [ACC_WIDTH+pnf_pkg::COEF_WIDTH-1:0]  prod_fb;
    logic signed [SAMPLE_WIDTH+pnf_pkg::COEF_WIDTH-1:0] prod_in;
    logic signed [PW-1:0]                             sum_full;
    logic signed [PW-1:0]                             shifted;

    assign prod_fb  = pole_reg * GAIN;
    assign prod_in  = white * FEED;
    assign sum_full = PW'(prod_fb) + PW'(prod_in) + HALF;
    assign shifted  = sum_full >>> pnf_pkg::COEF_FRAC;

    always_comb
    begin
        if (shifted > ACC_MAX)
        begin
            pole_next = ACC_MAX[ACC_WIDTH-1:0];
        end
        else if (shifted < ACC_MIN)
        begin
            pole_next = ACC_MIN[ACC_WIDTH-1:0];
        end
        else
        begin
            pole_next = shifted[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pole_reg <= '0;
        end
        else if (load)
        begin
            pole_reg <= pole_next;
        end
    end

    assign pole = pole_reg;

endmodule

### rtl/core/pnf_scale.sv
// ----------------------------------------------------------------------------
// Pink noise filter scaler
// Scales a white sample by a fixed coefficient with rounding and saturation.
// ----------------------------------------------------------------------------
module pnf_scale #(
    parameter int             SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH,
    parameter int             ACC_WIDTH    = pnf_pkg::ACC_WIDTH,
    parameter pnf_pkg::coef_t COEF         = '0
) (
    input  logic signed [SAMPLE_WIDTH-1:0] white,
    output logic signed [ACC_WIDTH-1:0]    term
);

    localparam int WIDE = (ACC_WIDTH > SAMPLE_WIDTH) ? ACC_WIDTH : SAMPLE_WIDTH;
    localparam int PW   = WIDE + pnf_pkg::COEF_WIDTH + 1;

    localparam logic signed [PW-1:0] HALF =
        {{(PW-pnf_pkg::COEF_FRAC){1'b0}}, 1'b1, {(pnf_pkg::COEF_FRAC-1){1'b0}}};
    localparam logic signed [PW-1:0] ACC_MAX =
        {{(PW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [PW-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [SAMPLE_WIDTH+pnf_pkg::COEF_WIDTH-1:0] prod;
    logic signed [PW-1:0]                               rounded;
    logic signed [PW-1:0]                               shifted;

    assign prod    = white * COEF;
    assign rounded = PW'(prod) + HALF;
    assign shifted = rounded >>> pnf_pkg::COEF_FRAC;

    always_comb
    begin
        if (shifted > ACC_MAX)
        begin
            term = ACC_MAX[ACC_WIDTH-1:0];
        end
        else if (shifted < ACC_MIN)
        begin
            term = ACC_MIN[ACC_WIDTH-1:0];
        end
        else
        begin
            term = shifted[ACC_WIDTH-1:0];
        end
    end

endmodule

### rtl/core/pnf_sum.sv
// ----------------------------------------------------------------------------
// Pink noise filter output sum
// Adds the poles, delayed and direct terms, saturates, and holds the result.
// ----------------------------------------------------------------------------
module pnf_sum #(
    parameter int ACC_WIDTH = pnf_pkg::ACC_WIDTH
) (
    input  logic                        clk,
    input  logic                        load,
    input  logic signed [ACC_WIDTH-1:0] poles [pnf_pkg::NUM_POLES],
    input  logic signed [ACC_WIDTH-1:0] delayed,
    input  logic signed [ACC_WIDTH-1:0] direct,
    output logic signed [ACC_WIDTH-1:0] result
);

    localparam int SW = ACC_WIDTH + 3;

    localparam logic signed [SW-1:0] ACC_MAX = {4'b0000, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;

    logic signed [SW-1:0]        total;
    logic signed [ACC_WIDTH-1:0] result_reg;
    logic signed [ACC_WIDTH-1:0] result_next;

    always_comb
    begin
        total = SW'(delayed) + SW'(direct);
        for (int i = 0; i < pnf_pkg::NUM_POLES; i++)
        begin
            total = total + SW'(poles[i]);
        end
    end

    always_comb
    begin
        if (total > ACC_MAX)
        begin
            result_next = ACC_MAX[ACC_WIDTH-1:0];
        end
        else if (total < ACC_MIN)
        begin
            result_next = ACC_MIN[ACC_WIDTH-1:0];
        end
        else
        begin
            result_next = total[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### test/pink_noise_filter_refined_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pink noise filter testbench
// Feeds white-noise items through the refined pole filter and checks each
// pink-noise result against a fixed-point filter model kept in the bench.
// Items are directed extremes first, then random bursts of noise, held
// full-scale levels and full-scale toggling, under three idle patterns.
// ----------------------------------------------------------------------------
module pink_noise_filter_refined_top_test;

    localparam int SAMPLE_WIDTH = pnf_pkg::SAMPLE_WIDTH;
    localparam int ACC_WIDTH    = pnf_pkg::ACC_WIDTH;

    typedef logic signed [SAMPLE_WIDTH-1:0] white_t;
    typedef logic signed [ACC_WIDTH-1:0]    pink_t;

    typedef enum int {
        BURST_NOISE,
        BURST_HOLD_MAX,
        BURST_HOLD_MIN,
        BURST_TOGGLE
    } burst_kind_t;

    localparam int     ROUND_SHIFT = 18;
    localparam longint POLE_DECAY [6] = '{261845, 260393, 254018, 227148, 144179, -199649};
    localparam longint POLE_INJECT [6] = '{14554, 19681, 40331, 81392, 139710, -4430};
    localparam longint DIRECT_SCALE = 140562;
    localparam longint DELAY_SCALE  = 30389;
    localparam longint ACC_MAX = (64'sd1 <<< (ACC_WIDTH - 1)) - 1;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam white_t WHITE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam white_t WHITE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    white_t white_sample;
    logic   out_valid;
    logic   out_stall = 1'b0;
    pink_t  pink_sample;

    longint pole_acc [6] = '{0, 0, 0, 0, 0, 0};
    longint delayed_white = 0;
    pink_t  expected_pink [$];
    int     mismatch_count = 0;
    int     sender_idle_pct = 0;
    int     receiver_idle_pct = 0;

    pink_noise_filter_refined_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .white_sample (white_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pink_sample  (pink_sample)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clamp_acc(longint x);
        if (x > ACC_MAX)
            return ACC_MAX;
        if (x < ACC_MIN)
            return ACC_MIN;
        return x;
    endfunction

    function automatic longint round_to_acc(longint x);
        return clamp_acc((x + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);
    endfunction

    function automatic pink_t filter_white(white_t w);
        longint wv;
        longint sum;
        wv = longint'(w);
        sum = 0;
        for (int i = 0; i < 6; i++)
        begin
            pole_acc[i] = round_to_acc(pole_acc[i] * POLE_DECAY[i] + wv * POLE_INJECT[i]);
            sum += pole_acc[i];
        end
        sum += delayed_white;
        sum += round_to_acc(wv * DIRECT_SCALE);
        delayed_white = round_to_acc(wv * DELAY_SCALE);
        return pink_t'(clamp_acc(sum));
    endfunction

    task automatic send_white(white_t w);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        white_sample <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_pink.push_back(filter_white(w));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_pink.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_random_bursts(int item_total);
        burst_kind_t kind;
        int          length;
        int          pick;
        int          sent;
        sent = 0;
        while (sent < item_total)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                kind = BURST_NOISE;
                length = $urandom_range(1, 40);
            end
            else if (pick < 72)
            begin
                kind = BURST_HOLD_MAX;
                length = $urandom_range(50, 150);
            end
            else if (pick < 84)
            begin
                kind = BURST_HOLD_MIN;
                length = $urandom_range(50, 150);
            end
            else
            begin
                kind = BURST_TOGGLE;
                length = $urandom_range(10, 60);
            end
            for (int n = 0; n < length && sent < item_total; n++)
            begin
                case (kind)
                    BURST_NOISE:    send_white(white_t'($urandom_range(0, 65535)));
                    BURST_HOLD_MAX: send_white(WHITE_MAX);
                    BURST_HOLD_MIN: send_white(WHITE_MIN);
                    default:        send_white(n[0] ? WHITE_MIN : WHITE_MAX);
                endcase
                sent++;
            end
        end
    endtask

    task automatic test_directed_extremes();
        white_t levels [$];
        levels = '{white_t'(0), WHITE_MAX, WHITE_MAX, WHITE_MIN, WHITE_MIN, WHITE_MAX,
                   WHITE_MIN, WHITE_MAX, WHITE_MIN, WHITE_MAX, WHITE_MIN, white_t'(1),
                   white_t'(-1), white_t'(0), white_t'(16384), white_t'(-16384),
                   16'sh5555, -16'sh5556, 16'sh2AAA, WHITE_MAX, WHITE_MAX, WHITE_MAX,
                   white_t'(0)};
        foreach (levels[i])
            send_white(levels[i]);
    endtask

    task automatic test_receiver_stalls();
        sender_idle_pct = 26;
        receiver_idle_pct = 72;
        run_random_bursts(550);
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct = 72;
        receiver_idle_pct = 26;
        run_random_bursts(275);
        wait_drained();
        run_random_bursts(275);
    endtask

    task automatic test_full_rate();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        run_random_bursts(550);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);

    always @(posedge clk)
    begin
        pink_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pink.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected pink sample %0d with nothing pending", pink_sample);
            end
            else
            begin
                want = expected_pink.pop_front();
                if (pink_sample !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Pink sample mismatch: expected %0d, got %0d",
                                 want, pink_sample);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        white_sample = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_extremes();
        wait_drained();
        test_receiver_stalls();
        wait_drained();
        test_sender_gaps();
        wait_drained();
        test_full_rate();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pnf_pkg.sv
rtl/core/pnf_pole.sv
rtl/core/pnf_scale.sv
rtl/core/pnf_sum.sv
rtl/core/pink_noise_filter_refined_top.sv
test/pink_noise_filter_refined_top_test.sv
